### rtl/fbpfl_pkg.sv
// ----------------------------------------------------------------------------
// fbpfl_pkg
// Shared constants and codes of the fixed block pool free list.
// ----------------------------------------------------------------------------
package fbpfl_pkg;

  localparam int unsigned MaxBlocksDefault = 256;

  localparam int unsigned ModeW   = 2;
  localparam int unsigned IndexW  = 8;
  localparam int unsigned CapW    = 9;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 9;

  localparam logic [CapW-1:0]   CapReset = 9'd8;
  localparam logic [CountW-1:0] CountMax = 9'd511;

  localparam logic [ModeW-1:0] MODE_INIT  = 2'd0;
  localparam logic [ModeW-1:0] MODE_ALLOC = 2'd1;
  localparam logic [ModeW-1:0] MODE_FREE  = 2'd2;

  localparam logic [StatusW-1:0] STATUS_OK        = 2'd0;
  localparam logic [StatusW-1:0] STATUS_EXHAUSTED = 2'd1;
  localparam logic [StatusW-1:0] STATUS_NULL_FREE = 2'd2;
  localparam logic [StatusW-1:0] STATUS_RANGE     = 2'd3;

endpackage

### rtl/fixed_block_pool_free_list_top.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_free_list_top
// Block pool allocator with a LIFO stack of freed blocks held in a link
// memory and a fresh-block counter for blocks never handed out.
// ----------------------------------------------------------------------------
// channel  dir  words                     fields (low bit up)
// s_*      in   one command per word      tuser: mode, block_present; tdata: block_index
// m_*      out  one result per command    tuser: status; tdata: granted_index, active_count
// cfg_*    in   capacity_in_use write     cfg_wdata_i: capacity_in_use
//
// Init, free, fresh allocate and the unused mode are answered from the idle
// state; an allocate that pops the freed stack goes through the pop state,
// which waits for the registered read of the link memory. Reset empties the
// pool and applies capacity 8; the link memory needs no clearing. A result
// waiting on m_tready_i holds s_tready_o low until the result is taken.
// ----------------------------------------------------------------------------
module fixed_block_pool_free_list_top #(
  parameter int unsigned MAX_BLOCKS = fbpfl_pkg::MaxBlocksDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,   // block_index[7:0]
  input  logic [2:0]  s_tuser_i,   // mode[1:0], block_present[2]
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [23:0] m_tdata_o,   // granted_index[7:0], active_count[16:8], zero[23:17]
  output logic [1:0]  m_tuser_o,   // status[1:0]
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i  // capacity_in_use[8:0]
);

  localparam int unsigned IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned LW = $clog2(MAX_BLOCKS + 1);
  localparam logic [LW-1:0] EmptyMark = LW'(MAX_BLOCKS);
  localparam int unsigned CapResetInt = int'(fbpfl_pkg::CapReset);
  localparam logic [LW-1:0] CapApplyReset =
    LW'((CapResetInt > MAX_BLOCKS) ? MAX_BLOCKS : CapResetInt);

  typedef enum logic {ST_IDLE, ST_POP} state_e;

  state_e                          state_q, state_d;
  logic [fbpfl_pkg::CapW-1:0]      cap_cfg_q;
  logic [LW-1:0]                   cap_q, cap_d;
  logic [LW-1:0]                   head_q, head_d;
  logic [LW-1:0]                   fresh_q, fresh_d;
  logic [fbpfl_pkg::CountW-1:0]    count_q, count_d;
  logic                            m_valid_q, m_valid_d;
  logic [fbpfl_pkg::StatusW-1:0]   m_status_q, m_status_d;
  logic [fbpfl_pkg::IndexW-1:0]    m_granted_q, m_granted_d;
  logic [fbpfl_pkg::CountW-1:0]    m_count_q, m_count_d;

  logic [LW-1:0] link_mem [MAX_BLOCKS];
  logic [LW-1:0] link_rdata_q;

  logic                          slot_free;
  logic                          accept;
  logic [fbpfl_pkg::ModeW-1:0]   mode;
  logic                          present;
  logic [fbpfl_pkg::IndexW-1:0]  idx;
  logic                          head_empty;
  logic                          link_we;
  logic                          link_re;
  logic [fbpfl_pkg::CountW-1:0]  count_inc;
  logic [fbpfl_pkg::CountW-1:0]  count_dec;
  logic [LW-1:0]                 cap_apply;

  assign mode       = s_tuser_i[1:0];
  assign present    = s_tuser_i[2];
  assign idx        = s_tdata_i;
  assign slot_free  = !m_valid_q || m_tready_i;
  assign s_tready_o = (state_q == ST_IDLE) && slot_free;
  assign accept     = s_tvalid_i && s_tready_o;
  assign head_empty = !(head_q < EmptyMark);
  assign count_inc  = (count_q == fbpfl_pkg::CountMax) ? count_q : count_q + 1'b1;
  assign count_dec  = (count_q == '0) ? count_q : count_q - 1'b1;

  always_comb begin
    int unsigned c;
    c = 32'(cap_cfg_q);
    if (c == 0) c = 1;
    if (c > MAX_BLOCKS) c = MAX_BLOCKS;
    cap_apply = LW'(c);
  end

  assign link_re = accept && (mode == fbpfl_pkg::MODE_ALLOC) && !head_empty;
  assign link_we = accept && (mode == fbpfl_pkg::MODE_FREE) && present &&
                   (32'(idx) < 32'(cap_q));

  always_comb begin
    state_d     = state_q;
    cap_d       = cap_q;
    head_d      = head_q;
    fresh_d     = fresh_q;
    count_d     = count_q;
    m_valid_d   = m_valid_q && !m_tready_i;
    m_status_d  = m_status_q;
    m_granted_d = m_granted_q;
    m_count_d   = m_count_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          m_status_d  = fbpfl_pkg::STATUS_OK;
          m_granted_d = '0;
          m_count_d   = count_q;
          m_valid_d   = 1'b1;
          case (mode)
            fbpfl_pkg::MODE_INIT: begin
              cap_d     = cap_apply;
              head_d    = EmptyMark;
              fresh_d   = '0;
              count_d   = '0;
              m_count_d = '0;
            end
            fbpfl_pkg::MODE_ALLOC: begin
              if (!head_empty) begin
                m_valid_d = 1'b0;
                state_d   = ST_POP;
              end else if (fresh_q < cap_q) begin
                m_granted_d = fbpfl_pkg::IndexW'(fresh_q);
                fresh_d     = fresh_q + 1'b1;
                count_d     = count_inc;
                m_count_d   = count_inc;
              end else begin
                m_status_d = fbpfl_pkg::STATUS_EXHAUSTED;
              end
            end
            fbpfl_pkg::MODE_FREE: begin
              if (!present) begin
                m_status_d = fbpfl_pkg::STATUS_NULL_FREE;
              end else if (!link_we) begin
                m_status_d = fbpfl_pkg::STATUS_RANGE;
              end else begin
                head_d    = LW'(idx);
                count_d   = count_dec;
                m_count_d = count_dec;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_POP: begin
        if (slot_free) begin
          m_valid_d   = 1'b1;
          m_status_d  = fbpfl_pkg::STATUS_OK;
          m_granted_d = fbpfl_pkg::IndexW'(head_q);
          m_count_d   = count_inc;
          count_d     = count_inc;
          head_d      = (link_rdata_q > EmptyMark) ? EmptyMark : link_rdata_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cap_cfg_q <= fbpfl_pkg::CapReset;
      cap_q     <= CapApplyReset;
      head_q    <= EmptyMark;
      fresh_q   <= '0;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      if (cfg_we_i) begin
        cap_cfg_q <= cfg_wdata_i;
      end
      cap_q     <= cap_d;
      head_q    <= head_d;
      fresh_q   <= fresh_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_status_q  <= m_status_d;
    m_granted_q <= m_granted_d;
    m_count_q   <= m_count_d;
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[IW'(idx)] <= head_q;
    end
    if (link_re) begin
      link_rdata_q <= link_mem[head_q[IW-1:0]];
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tuser_o  = m_status_q;
  assign m_tdata_o  = {7'b0, m_count_q, m_granted_q};

endmodule

### test/fixed_block_pool_free_list_top_tb.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_free_list_top_tb
// Drives init, allocate, free and unused-mode commands into the block pool
// under random source gaps and sink stalls. A pool model in the bench tracks
// the freed stack, the fresh-block counter and the active count, and checks
// every result word field by field. Capacities cover zero, one, small values,
// 256 and values above 256. One phase drives the active count to saturation.
// ----------------------------------------------------------------------------
module fixed_block_pool_free_list_top_tb;

  localparam logic [fbpfl_pkg::ModeW-1:0] MODE_UNUSED = 2'd3;
  localparam logic [8:0]                  EmptyMark   = 9'd256;

  typedef struct packed {
    logic [fbpfl_pkg::ModeW-1:0]  mode;
    logic [fbpfl_pkg::IndexW-1:0] index;
    logic                         present;
  } pool_cmd_t;

  typedef struct packed {
    logic [fbpfl_pkg::StatusW-1:0] status;
    logic [fbpfl_pkg::IndexW-1:0]  granted;
    logic [fbpfl_pkg::CountW-1:0]  count;
  } pool_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [7:0]  s_tdata_i = '0;
  logic [2:0]  s_tuser_i = '0;
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [23:0] m_tdata_o;
  logic [1:0]  m_tuser_o;
  logic        cfg_we_i = 1'b0;
  logic [8:0]  cfg_wdata_i = '0;

  fixed_block_pool_free_list_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // pool model state
  logic [8:0]                   link_mem [256];
  logic [8:0]                   freed_head = EmptyMark;
  logic [8:0]                   fresh_next = '0;
  logic [fbpfl_pkg::CountW-1:0] active_blocks = '0;
  logic [fbpfl_pkg::CapW-1:0]   applied_cap = fbpfl_pkg::CapReset;
  logic [fbpfl_pkg::CapW-1:0]   cap_reg = fbpfl_pkg::CapReset;

  pool_cmd_t       cmd_q[$];
  pool_result_t    due_results[$];
  pool_cmd_t       next_cmd;
  pool_cmd_t       taken_cmd;
  pool_result_t    want;
  logic            s_fire = 1'b0;
  bit              calm = 1'b0;
  int unsigned     errors = 0;
  int unsigned     n_cmds = 0;
  int unsigned     n_results = 0;
  int unsigned     n_settings = 0;
  int unsigned     peak_count = 0;

  function automatic pool_result_t predict_pool(pool_cmd_t c);
    pool_result_t r;
    r = '{fbpfl_pkg::STATUS_OK, '0, '0};
    case (c.mode)
      fbpfl_pkg::MODE_INIT: begin
        applied_cap   = (cap_reg == 0) ? 9'd1 : ((cap_reg > EmptyMark) ? EmptyMark : cap_reg);
        freed_head    = EmptyMark;
        fresh_next    = '0;
        active_blocks = '0;
      end
      fbpfl_pkg::MODE_ALLOC: begin
        if (freed_head < EmptyMark) begin
          r.granted  = freed_head[7:0];
          freed_head = link_mem[freed_head[7:0]];
          if (freed_head > EmptyMark) freed_head = EmptyMark;
          if (active_blocks < fbpfl_pkg::CountMax) active_blocks++;
        end else if (fresh_next < applied_cap) begin
          r.granted = fresh_next[7:0];
          fresh_next++;
          if (active_blocks < fbpfl_pkg::CountMax) active_blocks++;
        end else begin
          r.status = fbpfl_pkg::STATUS_EXHAUSTED;
        end
      end
      fbpfl_pkg::MODE_FREE: begin
        if (!c.present) begin
          r.status = fbpfl_pkg::STATUS_NULL_FREE;
        end else if ({1'b0, c.index} >= applied_cap) begin
          r.status = fbpfl_pkg::STATUS_RANGE;
        end else begin
          link_mem[c.index] = freed_head;
          freed_head        = {1'b0, c.index};
          if (active_blocks > 0) active_blocks--;
        end
      end
      default: ;
    endcase
    r.count = active_blocks;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // source driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid_i <= 1'b0;
    end else if (!s_tvalid_i || s_fire) begin
      if (cmd_q.size() != 0 && (calm || $urandom_range(99) >= 16)) begin
        next_cmd = cmd_q.pop_front();
        s_tvalid_i <= 1'b1;
        s_tdata_i  <= next_cmd.index;
        s_tuser_i  <= {next_cmd.present, next_cmd.mode};
      end else begin
        s_tvalid_i <= 1'b0;
      end
    end
    m_tready_i <= calm || ($urandom_range(99) >= 16);
  end

  // monitor and scoreboard
  always @(posedge clk_i) begin
    s_fire = rst_ni && s_tvalid_i && s_tready_o;
    if (s_fire) begin
      taken_cmd = '{s_tuser_i[1:0], s_tdata_i, s_tuser_i[2]};
      due_results.push_back(predict_pool(taken_cmd));
      n_cmds++;
    end
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      n_results++;
      if (due_results.size() == 0) begin
        $display("%0t: result word with none expected, status %0d data %0h",
                 $time, m_tuser_o, m_tdata_o);
        errors++;
      end else begin
        want = due_results.pop_front();
        check_field("status", want.status, m_tuser_o);
        check_field("granted_index", want.granted, m_tdata_o[7:0]);
        check_field("active_count", want.count, m_tdata_o[16:8]);
        if (32'(m_tdata_o[16:8]) > peak_count) peak_count = 32'(m_tdata_o[16:8]);
      end
    end
  end

  task automatic push_cmd(logic [fbpfl_pkg::ModeW-1:0] m, logic [fbpfl_pkg::IndexW-1:0] i,
                          logic p);
    cmd_q.push_back('{m, i, p});
  endtask

  task automatic settle();
    while (cmd_q.size() != 0 || s_tvalid_i || due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [fbpfl_pkg::CapW-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cap_reg = v;
    n_settings++;
  endtask

  task automatic queue_random(int unsigned n, int unsigned alloc_pct);
    int unsigned pick;
    int unsigned top;
    top = (cap_reg == 0) ? 1 : ((cap_reg > 256) ? 256 : cap_reg);
    for (int unsigned k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < alloc_pct)
        push_cmd(fbpfl_pkg::MODE_ALLOC, 8'($urandom_range(255)), 1'($urandom_range(1)));
      else if (pick < 93)
        push_cmd(fbpfl_pkg::MODE_FREE,
                 ($urandom_range(99) < 85) ? 8'($urandom_range(top - 1))
                                           : 8'($urandom_range(255)),
                 1'b1);
      else if (pick < 96)
        push_cmd(fbpfl_pkg::MODE_FREE, 8'($urandom_range(255)), 1'b0);
      else if (pick < 99)
        push_cmd(MODE_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)));
      else
        push_cmd(fbpfl_pkg::MODE_INIT, 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset capacity of 8
    repeat (3) push_cmd(fbpfl_pkg::MODE_ALLOC, 8'd0, 1'b0);
    push_cmd(fbpfl_pkg::MODE_FREE, 8'd1, 1'b1);
    push_cmd(fbpfl_pkg::MODE_FREE, 8'd1, 1'b1);
    push_cmd(fbpfl_pkg::MODE_ALLOC, 8'hff, 1'b1);
    push_cmd(fbpfl_pkg::MODE_ALLOC, 8'd0, 1'b0);
    push_cmd(fbpfl_pkg::MODE_FREE, 8'd5, 1'b0);
    push_cmd(fbpfl_pkg::MODE_FREE, 8'd8, 1'b1);
    push_cmd(fbpfl_pkg::MODE_FREE, 8'd255, 1'b1);
    push_cmd(MODE_UNUSED, 8'hff, 1'b1);
    repeat (7) push_cmd(fbpfl_pkg::MODE_ALLOC, 8'd0, 1'b0);
    push_cmd(fbpfl_pkg::MODE_INIT, 8'd0, 1'b0);
    push_cmd(fbpfl_pkg::MODE_FREE, 8'd0, 1'b1);
    push_cmd(fbpfl_pkg::MODE_ALLOC, 8'd0, 1'b0);
    push_cmd(fbpfl_pkg::MODE_ALLOC, 8'd0, 1'b0);
    push_cmd(fbpfl_pkg::MODE_FREE, 8'd7, 1'b1);
    settle();

    set_capacity(9'd0);
    push_cmd(fbpfl_pkg::MODE_INIT, 8'd0, 1'b0);
    queue_random(20, 55);
    settle();

    set_capacity(9'd2);
    push_cmd(fbpfl_pkg::MODE_INIT, 8'd0, 1'b0);
    queue_random(30, 50);
    settle();

    set_capacity(9'd256);
    push_cmd(fbpfl_pkg::MODE_INIT, 8'd0, 1'b0);
    repeat (258) push_cmd(fbpfl_pkg::MODE_ALLOC, 8'($urandom_range(255)),
                          1'($urandom_range(1)));
    queue_random(20, 45);
    settle();

    calm = 1'b1;
    set_capacity(9'd511);
    push_cmd(fbpfl_pkg::MODE_INIT, 8'd0, 1'b0);
    queue_random(60, 60);
    settle();
    calm = 1'b0;

    set_capacity(9'd5);
    push_cmd(fbpfl_pkg::MODE_INIT, 8'd0, 1'b0);
    queue_random(25, 50);
    settle();

    set_capacity(9'($urandom_range(255, 3)));
    push_cmd(fbpfl_pkg::MODE_INIT, 8'd0, 1'b0);
    queue_random(30, 55);
    settle();

    set_capacity(9'd300);
    push_cmd(fbpfl_pkg::MODE_INIT, 8'd0, 1'b0);
    queue_random(20, 50);
    settle();

    // self-linked block 0 gives an endless supply, so the count saturates
    set_capacity(9'd1);
    push_cmd(fbpfl_pkg::MODE_INIT, 8'd0, 1'b0);
    push_cmd(fbpfl_pkg::MODE_FREE, 8'd0, 1'b1);
    push_cmd(fbpfl_pkg::MODE_FREE, 8'd0, 1'b1);
    repeat (515) push_cmd(fbpfl_pkg::MODE_ALLOC, 8'd0, 1'b0);
    settle();

    // new capacity stays pending until the next init
    set_capacity(9'd64);
    queue_random(10, 50);
    settle();
    push_cmd(fbpfl_pkg::MODE_INIT, 8'd0, 1'b0);
    queue_random(20, 50);
    settle();

    set_capacity(9'($urandom_range(256, 1)));
    push_cmd(fbpfl_pkg::MODE_INIT, 8'd0, 1'b0);
    queue_random(25, 50);
    settle();
    repeat (10) @(posedge clk_i);

    $display("Ran %0d commands and checked %0d result words across %0d capacity writes.",
             n_cmds, n_results, n_settings);
    $display("Active count peaked at %0d; %0d mismatches seen.", peak_count, errors);
    if (errors == 0 && due_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding", due_results.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
